### rtl/acc_pkg.sv
// Shared types and constants for the arc center pipeline.
// No dependencies; used by every module of the block.
package acc_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int QBITS        = 35;

   localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
   localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
   localparam logic        [31:0] HALF_PI_Q30 = 32'd1686629713;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   localparam logic signed [33:0] ATAN_Q30 [0:CORDIC_STEPS-1] = '{
      34'sd843314857, 34'sd497837830, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
      34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
      34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
      34'sd1024,      34'sd512,       34'sd256,       34'sd128
   };

   // per-item data that rides along the pipeline
   typedef struct packed {
      logic signed [32:0] sum_x;
      logic signed [32:0] sum_y;
      logic signed [32:0] px;
      logic signed [32:0] py;
      logic               zero;
   } side_type;

   typedef struct packed {
      logic [64:0] num;
      logic        neg;
   } lane_type;

   typedef struct packed {
      logic [QBITS-1:0] q;
      logic             ovf;
      logic             neg;
   } quot_type;

endpackage

### rtl/acc_cordic.sv
// Rotation-mode CORDIC, one register stage per step, gives cos and sin of a/2.
// Depends on acc_pkg.
module acc_cordic import acc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [18:0]        angle,
   input  side_type           side_in,
   output logic               out_valid,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out,
   output side_type           side_out
);

   logic signed [33:0] x_ff [0:CORDIC_STEPS];
   logic signed [33:0] y_ff [0:CORDIC_STEPS];
   logic signed [33:0] z_ff [0:CORDIC_STEPS];
   side_type           side_ff [0:CORDIC_STEPS+1];
   logic [CORDIC_STEPS+1:0] valid_ff;
   logic signed [31:0] cos_ff, sin_ff;

   logic [31:0]        half_in;
   logic signed [33:0] x0_in, z0_in, xr, yr;

   assign half_in = {angle, 13'b0};

   always_comb begin
      if (half_in > HALF_PI_Q30) begin
         z0_in = $signed({2'b0, half_in}) - PI_Q30;
         x0_in = -CORDIC_K;
      end else begin
         z0_in = $signed({2'b0, half_in});
         x0_in = CORDIC_K;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[CORDIC_STEPS:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= '0;
         z_ff[0]    <= z0_in;
         side_ff[0] <= side_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN_Q30[i];
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN_Q30[i];
            end
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // round Q30 to Q28
   assign xr = (x_ff[CORDIC_STEPS] + 34'sd2) >>> 2;
   assign yr = (y_ff[CORDIC_STEPS] + 34'sd2) >>> 2;

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff                  <= xr[31:0];
         sin_ff                  <= yr[31:0];
         side_ff[CORDIC_STEPS+1] <= side_ff[CORDIC_STEPS];
      end
   end

   assign out_valid = valid_ff[CORDIC_STEPS+1];
   assign cos_out   = cos_ff;
   assign sin_out   = sin_ff;
   assign side_out  = side_ff[CORDIC_STEPS+1];

endmodule

### rtl/acc_mul.sv
// Two-stage magnitude multiply of the perpendicular by cos, split in halves.
// Depends on acc_pkg.
module acc_mul import acc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] cos_in,
   input  logic signed [31:0] sin_in,
   input  side_type           side_in,
   output logic               out_valid,
   output lane_type           lane_x,
   output lane_type           lane_y,
   output logic [31:0]        sin_mag,
   output side_type           side_out
);

   logic [1:0]  valid_ff;
   logic [48:0] hi_ff [0:1];
   logic [47:0] lo_ff [0:1];
   logic        neg1_ff [0:1];
   logic [31:0] sm1_ff, sm2_ff;
   side_type    side1_ff, side2_ff;
   lane_type    lx_ff, ly_ff;

   logic [32:0] pm_x, pm_y;
   logic [31:0] cm, sm;

   assign pm_x = side_in.px[32] ? 33'(-side_in.px) : side_in.px;
   assign pm_y = side_in.py[32] ? 33'(-side_in.py) : side_in.py;
   assign cm   = cos_in[31] ? 32'(-cos_in) : cos_in;
   assign sm   = sin_in[31] ? 32'(-sin_in) : sin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff[0]   <= pm_x[32:16] * cm;
         lo_ff[0]   <= pm_x[15:0] * cm;
         hi_ff[1]   <= pm_y[32:16] * cm;
         lo_ff[1]   <= pm_y[15:0] * cm;
         neg1_ff[0] <= side_in.px[32] ^ cos_in[31] ^ sin_in[31];
         neg1_ff[1] <= side_in.py[32] ^ cos_in[31] ^ sin_in[31];
         sm1_ff     <= sm;
         side1_ff   <= side_in;

         lx_ff.num  <= {hi_ff[0], 16'b0} + {17'b0, lo_ff[0]};
         lx_ff.neg  <= neg1_ff[0];
         ly_ff.num  <= {hi_ff[1], 16'b0} + {17'b0, lo_ff[1]};
         ly_ff.neg  <= neg1_ff[1];
         sm2_ff     <= sm1_ff;
         side2_ff   <= side1_ff;
      end
   end

   assign out_valid = valid_ff[1];
   assign lane_x    = lx_ff;
   assign lane_y    = ly_ff;
   assign sin_mag   = sm2_ff;
   assign side_out  = side2_ff;

endmodule

### rtl/acc_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// Depends on acc_pkg.
module acc_div import acc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  lane_type    lane_x,
   input  lane_type    lane_y,
   input  logic [31:0] sin_mag,
   input  side_type    side_in,
   output logic        out_valid,
   output quot_type    quot_x,
   output quot_type    quot_y,
   output side_type    side_out
);

   localparam int RW = 67;

   logic [RW-1:0]    r_ff   [0:QBITS][0:1];
   logic [QBITS-1:0] q_ff   [0:QBITS][0:1];
   logic             ovf_ff [0:QBITS][0:1];
   logic             neg_ff [0:QBITS][0:1];
   logic [31:0]      sm_ff  [0:QBITS];
   side_type         side_ff[0:QBITS];
   logic [QBITS:0]   valid_ff;

   lane_type    lane_in [0:1];
   logic [RW-1:0] lim;

   assign lane_in[0] = lane_x;
   assign lane_in[1] = lane_y;
   assign lim        = {sin_mag, {QBITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QBITS-1:0], in_valid};
      end
   end

   // entry: quotient that would not fit clips the coordinate anyway
   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 2; l++) begin
            r_ff[0][l]   <= {2'b0, lane_in[l].num};
            q_ff[0][l]   <= '0;
            ovf_ff[0][l] <= (lane_in[l].num != '0) && ({2'b0, lane_in[l].num} >= lim);
            neg_ff[0][l] <= lane_in[l].neg;
         end
         sm_ff[0]   <= sin_mag;
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 0; k < QBITS; k++) begin : g_bit
      localparam int B = QBITS - 1 - k;
      logic [RW-1:0] dv;
      assign dv = {{(RW-32){1'b0}}, sm_ff[k]} << B;
      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 2; l++) begin
               // zero divisor: a nonzero numerator is already flagged, so q stays 0
               if (sm_ff[k] != '0 && r_ff[k][l] >= dv) begin
                  r_ff[k+1][l] <= r_ff[k][l] - dv;
                  q_ff[k+1][l] <= q_ff[k][l] | (QBITS'(1) << B);
               end else begin
                  r_ff[k+1][l] <= r_ff[k][l];
                  q_ff[k+1][l] <= q_ff[k][l];
               end
               ovf_ff[k+1][l] <= ovf_ff[k][l];
               neg_ff[k+1][l] <= neg_ff[k][l];
            end
            sm_ff[k+1]   <= sm_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid  = valid_ff[QBITS];
   assign quot_x.q   = q_ff[QBITS][0];
   assign quot_x.ovf = ovf_ff[QBITS][0];
   assign quot_x.neg = neg_ff[QBITS][0];
   assign quot_y.q   = q_ff[QBITS][1];
   assign quot_y.ovf = ovf_ff[QBITS][1];
   assign quot_y.neg = neg_ff[QBITS][1];
   assign side_out   = side_ff[QBITS];

endmodule

### rtl/arc_center_from_chord.sv
// Top level of the arc center pipeline: entry, CORDIC, multiply, divide, output.
// Depends on acc_pkg, acc_cordic, acc_mul and acc_div.

// Arc center from two endpoints and a sweep angle. The center is the chord
// midpoint plus the chord perpendicular scaled by cos(a/2)/sin(a/2)/2; cos and
// sin of the half angle come from a 24-step CORDIC. One word is accepted every
// cycle while the pipe is not holding; the result word passes through 66
// register stages (1 entry, 26 CORDIC, 2 multiply, 36 divide, plus the output
// register), a depth set by the CORDIC steps and the 35-bit divider. The
// whole pipe advances together and holds while a result waits on rsp_tready.
// A zero sweep gives (0,0) with status 1; a clipped coordinate gives status 2.
module arc_center_from_chord import acc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // start_x[31:0], start_y[63:32], end_x[95:64], end_y[127:96],
   // sweep_angle[146:128], zero pad
   input  logic [151:0] req_tdata,
   input  logic         req_tuser,   // positive_turn
   input  logic         req_tvalid,
   output logic         req_tready,
   // center_x[31:0], center_y[63:32], status[65:64], zero pad
   output logic [71:0]  rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready
);

   logic signed [31:0] x1, y1, x2, y2;
   logic [18:0]        sweep;
   logic               en;
   logic signed [32:0] dx, dy;
   side_type           side_in;

   // entry register
   logic        e_valid_ff;
   logic [18:0] e_sweep_ff;
   side_type    e_side_ff;

   logic               c_valid;
   logic signed [31:0] c_cos, c_sin;
   side_type           c_side;

   logic        m_valid;
   lane_type    m_lx, m_ly;
   logic [31:0] m_sm;
   side_type    m_side;

   logic     d_valid;
   quot_type d_qx, d_qy;
   side_type d_side;

   logic               rsp_valid_ff;
   logic signed [31:0] cx_ff, cy_ff, cx_in, cy_in;
   logic [1:0]         st_ff, st_in;
   logic               sat_x, sat_y;

   assign x1    = req_tdata[31:0];
   assign y1    = req_tdata[63:32];
   assign x2    = req_tdata[95:64];
   assign y2    = req_tdata[127:96];
   assign sweep = req_tdata[146:128];

   // whole pipe moves when the output slot is free or being taken
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   assign dx = 33'(x2) - 33'(x1);
   assign dy = 33'(y2) - 33'(y1);

   always_comb begin
      side_in.sum_x = 33'(x1) + 33'(x2);
      side_in.sum_y = 33'(y1) + 33'(y2);
      side_in.px    = req_tuser ? -dy : dy;
      side_in.py    = req_tuser ? dx : -dx;
      side_in.zero  = (sweep == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_sweep_ff <= sweep;
         e_side_ff  <= side_in;
      end
   end

   acc_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (e_valid_ff),
      .angle     (e_sweep_ff),
      .side_in   (e_side_ff),
      .out_valid (c_valid),
      .cos_out   (c_cos),
      .sin_out   (c_sin),
      .side_out  (c_side)
   );

   acc_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_valid),
      .cos_in    (c_cos),
      .sin_in    (c_sin),
      .side_in   (c_side),
      .out_valid (m_valid),
      .lane_x    (m_lx),
      .lane_y    (m_ly),
      .sin_mag   (m_sm),
      .side_out  (m_side)
   );

   acc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_valid),
      .lane_x    (m_lx),
      .lane_y    (m_ly),
      .sin_mag   (m_sm),
      .side_in   (m_side),
      .out_valid (d_valid),
      .quot_x    (d_qx),
      .quot_y    (d_qy),
      .side_out  (d_side)
   );

   // signed offset, midpoint round and clip
   function automatic logic signed [31:0] finish(input logic signed [32:0] sum,
                                                  input quot_type qt,
                                                  output logic sat);
      logic signed [37:0] qs, tot;
      logic signed [36:0] half;
      begin
         if (qt.ovf) begin
            qs = qt.neg ? -(38'sd1 <<< QBITS) : (38'sd1 <<< QBITS);
         end else begin
            qs = qt.neg ? -$signed({3'b0, qt.q}) : $signed({3'b0, qt.q});
         end
         tot  = 38'(sum) + qs + 38'sd1;
         half = 37'(tot >>> 1);
         sat  = 1'b0;
         if (half > 37'sd2147483647) begin
            sat    = 1'b1;
            finish = 32'sh7FFFFFFF;
         end else if (half < -37'sd2147483648) begin
            sat    = 1'b1;
            finish = 32'sh80000000;
         end else begin
            finish = half[31:0];
         end
      end
   endfunction

   always_comb begin
      cx_in = finish(d_side.sum_x, d_qx, sat_x);
      cy_in = finish(d_side.sum_y, d_qy, sat_y);
      if (d_side.zero) begin
         cx_in = '0;
         cy_in = '0;
         st_in = ST_ZERO;
      end else if (sat_x || sat_y) begin
         st_in = ST_SAT;
      end else begin
         st_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         st_ff <= st_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, st_ff, cy_ff, cx_ff};

   // zero sweep always reports the origin
   a_zero_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff == ST_ZERO |-> cx_ff == '0 && cy_ff == '0)
      else $error("zero sweep result not at origin");

   // a saturated status means some coordinate sits at a rail
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff == ST_SAT |->
         cx_ff == 32'sh7FFFFFFF || cx_ff == 32'sh80000000 ||
         cy_ff == 32'sh7FFFFFFF || cy_ff == 32'sh80000000)
      else $error("saturated status without clipped coordinate");

   // status code 3 is never produced
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> st_ff != 2'd3)
      else $error("illegal status code");

   // pipe freezes exactly while the output word is held
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(d_valid) && rsp_valid_ff)
      else $error("pipeline moved during stall");

endmodule
